@@ sv/hessian_determinant_3x3_top_macros.svh @@
// assertion macros shared by the hessian determinant checker
// no dependencies; included by files that carry concurrent assertions
`ifndef HESSIAN_DETERMINANT_3X3_TOP_MACROS_SVH
`define HESSIAN_DETERMINANT_3X3_TOP_MACROS_SVH

// clocked property, ignored while reset is asserted
`define HDET_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property that also holds during reset
`define HDET_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/hdet_pkg.sv @@
// shared types and constants of the hessian determinant filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hdet_pkg;

    localparam int PIX_W       = 16;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int DIFF_W      = PIX_W + 2;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int RESP_W      = 40;
    localparam int STORE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    // frame geometry after clamping, plus restart strobe on any register write
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             restart;
    } geom_t;

    // one classified window: derivative terms of an interior pixel
    typedef struct packed {
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic signed [DIFF_W-1:0] lxx;
        logic signed [DIFF_W-1:0] lyy;
        logic signed [DIFF_W-1:0] dxy;
        logic                     last;
    } diff_item_t;

endpackage

@@ sv/hdet_front.sv @@
// front end: pixel intake, position tracking, line stores, 3x3 window, differences
// depends on hdet_pkg; pushes interior windows into hdet_queue
`timescale 1ns / 1ps

module hdet_front import hdet_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  geom_t              geom,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel,
    input  logic [QCNT_W-1:0]  q_count,
    output logic               push,
    output diff_item_t         push_item
);

    logic [COORD_W-1:0] row_reg, col_reg;
    logic               v1_reg;
    logic               emit_reg, last_reg;
    logic [COORD_W-1:0] crow_reg, ccol_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PIX_W-1:0]   pix_reg, top_reg, mid_reg;
    logic [PIX_W-1:0]   win_reg [6];
    logic [PIX_W-1:0]   upper_store  [STORE_DEPTH];
    logic [PIX_W-1:0]   middle_store [STORE_DEPTH];

    logic accept, last_col, last_row;
    logic [DIM_W-1:0] col_plus, row_plus;

    // room for the item in flight plus the new one
    assign s_ready  = ({1'b0, q_count} + {{QCNT_W{1'b0}}, v1_reg}) < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_valid && s_ready;
    assign col_plus = {1'b0, col_reg} + DIM_W'(1);
    assign row_plus = {1'b0, row_reg} + DIM_W'(1);
    assign last_col = col_plus >= geom.width;
    assign last_row = row_plus >= geom.height;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (geom.restart) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_plus[COORD_W-1:0];
            end else begin
                col_reg <= col_plus[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg  <= s_pixel;
            idx_reg  <= col_reg[IDX_W-1:0];
            emit_reg <= (row_reg >= COORD_W'(2)) && (col_reg >= COORD_W'(2));
            last_reg <= last_col && last_row;
            crow_reg <= row_reg - COORD_W'(1);
            ccol_reg <= col_reg - COORD_W'(1);
        end
    end

    // line stores: registered read on intake, write back in the cycle after intake
    always_ff @(posedge aclk) begin
        if (accept) begin
            top_reg <= upper_store[col_reg[IDX_W-1:0]];
            mid_reg <= middle_store[col_reg[IDX_W-1:0]];
        end
        if (v1_reg) begin
            upper_store[idx_reg]  <= mid_reg;
            middle_store[idx_reg] <= pix_reg;
        end
    end

    // window: 0 up-left 1 up-mid 2 mid-left 3 mid-mid 4 low-left 5 low-mid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (v1_reg) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_reg;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_reg;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= pix_reg;
        end
    end

    function automatic logic signed [DIFF_W-1:0] ext(input logic [PIX_W-1:0] v);
        return $signed({2'b00, v});
    endfunction

    always_comb begin
        push_item.row  = crow_reg;
        push_item.col  = ccol_reg;
        push_item.lxx  = ext(win_reg[2]) - (ext(win_reg[3]) <<< 1) + ext(mid_reg);
        push_item.lyy  = ext(win_reg[1]) - (ext(win_reg[3]) <<< 1) + ext(win_reg[5]);
        push_item.dxy  = ext(top_reg) - ext(win_reg[0]) + ext(win_reg[4]) - ext(pix_reg);
        push_item.last = last_reg;
    end

    assign push = v1_reg && emit_reg;

endmodule

@@ sv/hdet_queue.sv @@
// short queue between front and back ends
// depends on hdet_pkg for the item type and depth
`timescale 1ns / 1ps

module hdet_queue import hdet_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  diff_item_t        push_item,
    input  logic              pop,
    output logic              out_valid,
    output diff_item_t        out_item,
    output logic [QCNT_W-1:0] count
);

    diff_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_pop;

    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/hdet_back.sv @@
// back end: products, determinant and output register
// depends on hdet_pkg; pops items from hdet_queue
`timescale 1ns / 1ps

module hdet_back import hdet_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  diff_item_t               in_item,
    output logic                     in_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [COORD_W-1:0]       m_resp_row,
    output logic [COORD_W-1:0]       m_resp_col,
    output logic signed [RESP_W-1:0] m_response,
    output logic                     m_frame_done
);

    logic                     mul_v_reg, out_v_reg;
    logic signed [PROD_W-1:0] pxy_reg, dsq_reg;
    logic [COORD_W-1:0]       mrow_reg, mcol_reg, orow_reg, ocol_reg;
    logic                     mlast_reg, olast_reg;
    logic signed [RESP_W-1:0] resp_reg;
    logic                     out_free, mul_adv;

    assign out_free = !out_v_reg || m_ready;
    assign mul_adv  = !mul_v_reg || out_free;
    assign in_pop   = in_valid && mul_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (mul_adv) begin
                mul_v_reg <= in_valid;
            end
            if (out_free) begin
                out_v_reg <= mul_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_adv) begin
            pxy_reg   <= in_item.lxx * in_item.lyy;
            dsq_reg   <= in_item.dxy * in_item.dxy;
            mrow_reg  <= in_item.row;
            mcol_reg  <= in_item.col;
            mlast_reg <= in_item.last;
        end
        if (out_free) begin
            resp_reg  <= (RESP_W'(pxy_reg) <<< 4) - RESP_W'(dsq_reg);
            orow_reg  <= mrow_reg;
            ocol_reg  <= mcol_reg;
            olast_reg <= mlast_reg;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_resp_row   = orow_reg;
    assign m_resp_col   = ocol_reg;
    assign m_response   = resp_reg;
    assign m_frame_done = olast_reg;

endmodule

@@ sv/hessian_determinant_3x3_top.sv @@
// hessian determinant 3x3: one pixel a cycle in while s_ready is high, one response per interior centre out
// path: pixel (r, c) is registered at intake, queued and multiplied; centre (r-1, c-1) leaves the output register
// throughput: 1 pixel per cycle while s_ready is high, one line store read and one write per pixel; queue
// credit holds off the input only while the response channel is back-pressured
// reset: synchronous active-low aresetn clears position, window, queue and pipeline;
// line stores are not cleared (no clearing pass), rows 0 and 1 refill them
`timescale 1ns / 1ps

module hessian_determinant_3x3_top import hdet_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // pixel request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIX_W-1:0]         s_pixel,
    // response request channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [COORD_W-1:0]       m_resp_row,
    output logic [COORD_W-1:0]       m_resp_col,
    output logic signed [RESP_W-1:0] m_response,
    output logic                     m_frame_done,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int WIDTH_HI = (MAX_WIDTH < STORE_DEPTH) ? MAX_WIDTH : STORE_DEPTH;

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic               cfg_write;
    logic               reg_sel;
    geom_t              geom;
    logic               push, pop, q_valid;
    diff_item_t         push_item, q_item;
    logic [QCNT_W-1:0]  q_count;

    // clamp a register value to the legal range of a dimension
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(MIN_DIM)) begin
            r = DIM_W'(MIN_DIM);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // apb: always ready, write lands on the access cycle
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // read back the raw register value
    always_comb begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = {{(32 - DIM_W){1'b0}}, width_reg};
            REG_FRAME_HEIGHT: prdata = {{(32 - DIM_W){1'b0}}, height_reg};
            default:          prdata = '0;
        endcase
    end

    // any register write restarts the frame position
    always_comb begin
        geom.width   = clamp_dim(width_reg, DIM_W'(WIDTH_HI));
        geom.height  = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
        geom.restart = cfg_write;
    end

    // front: intake, line stores, window and second differences
    hdet_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue, front holds off by credit so it never overflows
    hdet_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .out_valid (q_valid),
        .out_item  (q_item),
        .count     (q_count)
    );

    // back: multiply stage then determinant into the output register
    hdet_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_item      (q_item),
        .in_pop       (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_resp_row   (m_resp_row),
        .m_resp_col   (m_resp_col),
        .m_response   (m_response),
        .m_frame_done (m_frame_done)
    );

endmodule

@@ sv/hdet_checker.sv @@
// port-level checks for the hessian determinant filter, bound to the top level
// depends on hdet_pkg and hessian_determinant_3x3_top_macros.svh
`timescale 1ns / 1ps
`include "hessian_determinant_3x3_top_macros.svh"

module hdet_checker import hdet_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [COORD_W-1:0]       m_resp_row,
    input logic [COORD_W-1:0]       m_resp_col,
    input logic signed [RESP_W-1:0] m_response,
    input logic                     pready
);

    `HDET_CHECK_ALWAYS(a_pready_high, aclk, pready, "pready dropped")

    `HDET_CHECK(a_row_interior, aclk, aresetn,
        m_valid |-> (m_resp_row != '0) && (m_resp_row != '1), "response row on border")

    `HDET_CHECK(a_col_interior, aclk, aresetn,
        m_valid |-> (m_resp_col != '0) && (m_resp_col != '1), "response column on border")

    `HDET_CHECK(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_response), "stalled response changed")

endmodule

bind hessian_determinant_3x3_top hdet_checker u_hdet_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_resp_row (m_resp_row),
    .m_resp_col (m_resp_col),
    .m_response (m_response),
    .pready     (pready)
);
